>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the RTL; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define CHK_IMPLY(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHK_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`else

`define CHK_IMPLY(lbl, clk, rst_n, a, b, msg)
`define CHK_NEXT(lbl, clk, rst_n, a, b, msg)

`endif

`endif

>>> hw/rtl/tscp_pkg.sv
// ----------------------------------------------------------------------------
// tscp_pkg
// Types, command codes and constants of the trimmed seconds clock.
// ----------------------------------------------------------------------------
package tscp_pkg;

    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DATA_W);
    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 4;

    // Nominal timer ticks in one second plus the trim offset
    localparam logic [DATA_W-1:0] SYS_TIMER_TICKS_1S = 32'd16000000;
    localparam logic [DATA_W-1:0] TICK_TRIM          = 32'd5000;
    localparam logic [DATA_W-1:0] TPS_RESET          = SYS_TIMER_TICKS_1S + TICK_TRIM;

    localparam int NUM_CHANNELS_DEF = 16;

    // Command codes; the fourth code does nothing
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] timer_now;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] period_seconds;
        logic [DATA_W-1:0] new_time;
    } in_word_t;

    typedef struct packed {
        logic              reached;
        logic [DATA_W-1:0] current_time;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV,
        ST_POLL_UPD,
        ST_QDECIDE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_step;
        logic poll_update;
        logic load_time;
        logic q_read;
        logic q_decide;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             tps_zero;
        logic             ch_in_range;
        logic             div_last;
        logic             hit;
    } dp_status_t;

endpackage

>>> hw/rtl/tscp_ctrl.sv
// ----------------------------------------------------------------------------
// tscp_ctrl
// Sequencer: accepts one word, steps the datapath through it, holds the result.
// ----------------------------------------------------------------------------
module tscp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tscp_pkg::dp_status_t stat,
    output tscp_pkg::dp_cmd_t    cmd
);
    import tscp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (stat.command == CMD_POLL && !stat.tps_zero)
                    state_next = ST_DIV;
                else if (stat.command == CMD_QUERY && stat.ch_in_range)
                    state_next = ST_QDECIDE;
                else
                    state_next = ST_DONE;
            end
            ST_DIV:
            begin
                if (stat.div_last)
                    state_next = ST_POLL_UPD;
            end
            ST_POLL_UPD: state_next = ST_DONE;
            ST_QDECIDE:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:     cmd.capture = in_valid;
            ST_DISPATCH:
            begin
                cmd.div_start = (stat.command == CMD_POLL) && !stat.tps_zero;
                cmd.q_read    = (stat.command == CMD_QUERY) && stat.ch_in_range;
                cmd.load_time = (stat.command == CMD_SET);
            end
            ST_DIV:      cmd.div_step    = 1'b1;
            ST_POLL_UPD: cmd.poll_update = 1'b1;
            ST_QDECIDE:  cmd.q_decide    = 1'b1;
            ST_DONE:     cmd.load_out    = !out_valid_reg || !out_stall;
            default:     cmd = '0;
        endcase
    end

    // Hold the result word until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/tscp_dp.sv
// ----------------------------------------------------------------------------
// tscp_dp
// Seconds count, second mark, bit-serial divider and period channel store.
// ----------------------------------------------------------------------------
module tscp_dp #(
    parameter int NUM_CHANNELS = tscp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tscp_pkg::DATA_W-1:0]    cfg_wdata,
    input  tscp_pkg::in_word_t             in_data,
    input  tscp_pkg::dp_cmd_t              cmd,
    output tscp_pkg::dp_status_t           stat,
    output tscp_pkg::out_word_t            out_data
);
    import tscp_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W = (CH_W > CHAN_W) ? CH_W : CHAN_W;

    in_word_t            item_reg;
    out_word_t           out_reg;
    logic [DATA_W-1:0]   tps_reg;
    logic [DATA_W-1:0]   seconds_reg;
    logic [DATA_W-1:0]   mark_reg;
    logic                hit_reg;

    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   rem_next;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   quo_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DATA_W:0]     shifted;
    logic                fits;

    logic [DATA_W-1:0]   fire_mem [NUM_CHANNELS];
    logic [DATA_W-1:0]   fire_rd_reg;
    logic [NUM_CHANNELS-1:0] seen_reg;
    logic [NUM_CHANNELS-1:0] fvalid_reg;

    logic [IDX_W-1:0]    ch_ext;
    logic [CH_W-1:0]     idx;
    logic                in_range;
    logic [DATA_W-1:0]   last_fire;
    logic [DATA_W-1:0]   elapsed;
    logic                was_seen;
    logic                period_hit;
    logic                fire_we;

    // Channel index and range check
    assign ch_ext   = IDX_W'(item_reg.channel);
    assign idx      = ch_ext[CH_W-1:0];
    assign in_range = {{(DATA_W-CHAN_W){1'b0}}, item_reg.channel} < DATA_W'(NUM_CHANNELS);

    // Restoring divide step: one quotient bit per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DATA_W-1]};
        fits     = shifted >= {1'b0, tps_reg};
        rem_next = fits ? DATA_W'(shifted - {1'b0, tps_reg}) : shifted[DATA_W-1:0];
        quo_next = {quo_reg[DATA_W-2:0], fits};
    end

    // Period decision; a never-fired channel reads as time zero
    always_comb
    begin
        was_seen   = seen_reg[idx];
        last_fire  = fvalid_reg[idx] ? fire_rd_reg : '0;
        elapsed    = seconds_reg - last_fire;
        period_hit = !was_seen || (elapsed >= item_reg.period_seconds);
        fire_we    = cmd.q_decide && was_seen && (elapsed >= item_reg.period_seconds);
    end

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.load_out)
        begin
            out_reg.reached      <= hit_reg;
            out_reg.current_time <= seconds_reg;
        end
    end

    // Divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= item_reg.timer_now - mark_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Channel fire-time store
    always_ff @(posedge clk)
    begin
        if (fire_we)
            fire_mem[idx] <= seconds_reg;
        if (cmd.q_read)
            fire_rd_reg <= fire_mem[idx];
    end

    // Clock state, seen and fired flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg     <= TPS_RESET;
            seconds_reg <= '0;
            mark_reg    <= '0;
            hit_reg     <= 1'b0;
            cnt_reg     <= '0;
            seen_reg    <= '0;
            fvalid_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                tps_reg <= cfg_wdata;
            if (cmd.capture)
                hit_reg <= 1'b0;
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 1'b1;
            // mark + n*tps equals timer_now - remainder
            if (cmd.poll_update)
            begin
                mark_reg    <= item_reg.timer_now - rem_reg;
                seconds_reg <= seconds_reg + quo_reg;
            end
            if (cmd.load_time)
                seconds_reg <= item_reg.new_time;
            if (cmd.q_decide)
            begin
                hit_reg       <= period_hit;
                seen_reg[idx] <= 1'b1;
                if (fire_we)
                    fvalid_reg[idx] <= 1'b1;
            end
        end
    end

    assign stat.command     = item_reg.command;
    assign stat.tps_zero    = (tps_reg == '0);
    assign stat.ch_in_range = in_range;
    assign stat.div_last    = (cnt_reg == CNT_W'(DATA_W - 1));
    assign stat.hit         = hit_reg;
    assign out_data         = out_reg;

endmodule

>>> hw/rtl/trimmed_seconds_clock_with_periods.sv
// ----------------------------------------------------------------------------
// trimmed_seconds_clock_with_periods
// Seconds clock from timer samples, with period channels and time loading.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | word
//  ---------+----------------------------+------------------------------------
//  in       | in_valid / in_stall        | in_data  (command, timer, channel..)
//  out      | out_valid / out_stall      | out_data (reached, current_time)
//  cfg      | cfg_we                     | cfg_wdata (ticks per second)
//
//  A poll runs the elapsed ticks through the 32-step bit-serial divider; a
//  period query makes one registered read of the channel store. Set time, the
//  unused code and a poll with zero ticks per second go straight to the result.
//  One word is worked at a time; the next is accepted while a result waits.
//  Reset clears the clock, the second mark and all channel flags at once;
//  a stalled output holds the result and the sequencer waits before overwriting.
// ----------------------------------------------------------------------------
module trimmed_seconds_clock_with_periods #(
    parameter int NUM_CHANNELS = tscp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tscp_pkg::DATA_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  tscp_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output tscp_pkg::out_word_t         out_data
);
    import tscp_pkg::*;

`include "assert_macros.svh"

    dp_cmd_t    cmd;
    dp_status_t stat;
    logic       out_hit;
    logic       cur_query;

    tscp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tscp_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    assign out_hit   = cmd.load_out && stat.hit;
    assign cur_query = (stat.command == CMD_QUERY);

    // Block is busy in the cycle after it takes a word
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "not busy")
    // Only a period query may report reached
    `CHK_IMPLY(a_hit_only_query, clk, rst_n, out_hit, cur_query, "reached on a non-query")
    // Poll update follows the last divide step
    `CHK_IMPLY(a_upd_after_div, clk, rst_n, cmd.poll_update, $past(cmd.div_step), "no divide")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the trimmed seconds clock. A queue of command words
// feeds a clocked driver, a clocked monitor checks every reading against a
// predictor that keeps its own seconds count, second mark and channel store.
// Phases run with different ticks-per-second settings, written while idle.
// ----------------------------------------------------------------------------
module tb;
    import tscp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int N_CHAN      = NUM_CHANNELS_DEF;
    localparam int IDLE_PCT    = 31;
    localparam int SETTLE_CYC  = 60;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 283;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_data;

    // Stimulus and expectation stores
    in_word_t    pending_words[$];
    out_word_t   due_readings[$];
    int          idle_pct = IDLE_PCT;
    int          fault_count = 0;

    // Predictor state
    logic [31:0] model_tps = TPS_RESET;
    logic [31:0] model_seconds = '0;
    logic [31:0] model_mark = '0;
    logic [31:0] chan_fire_time[N_CHAN];
    logic        chan_seen[N_CHAN];

    // Generator state
    logic [31:0] tps_cur = TPS_RESET;
    logic [31:0] timer_clock = '0;

    trimmed_seconds_clock_with_periods u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Work out the reading that one accepted word must produce
    function automatic void predict_reading(input in_word_t w);
        out_word_t   r;
        logic [31:0] elapsed;
        logic [31:0] whole;
        r.reached = 1'b0;
        case (w.command)
            CMD_POLL:
            begin
                if (model_tps != '0)
                begin
                    elapsed = w.timer_now - model_mark;
                    whole = elapsed / model_tps;
                    model_mark = model_mark + whole * model_tps;
                    model_seconds = model_seconds + whole;
                end
            end
            CMD_QUERY:
            begin
                if (int'(w.channel) < N_CHAN)
                begin
                    if (!chan_seen[w.channel])
                    begin
                        chan_seen[w.channel] = 1'b1;
                        r.reached = 1'b1;
                    end
                    else if (model_seconds - chan_fire_time[w.channel] >= w.period_seconds)
                    begin
                        chan_fire_time[w.channel] = model_seconds;
                        r.reached = 1'b1;
                    end
                end
            end
            CMD_SET:
                model_seconds = w.new_time;
            default: ;
        endcase
        r.current_time = model_seconds;
        due_readings.push_back(r);
    endfunction

    function automatic void report_fault(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    // Driver: present queued words, hold a word until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_reading(in_data);
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_data  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each reading against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_readings.size() == 0)
                    report_fault("reading with none due", '0, out_data.current_time);
                else
                begin
                    want = due_readings.pop_front();
                    if (out_data.reached !== want.reached)
                        report_fault("reached", want.reached, out_data.reached);
                    if (out_data.current_time !== want.current_time)
                        report_fault("current_time", want.current_time,
                                     out_data.current_time);
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic in_word_t make_word(input logic [CMD_W-1:0] cmd,
                                           input logic [31:0] timer,
                                           input logic [CHAN_W-1:0] ch,
                                           input logic [31:0] period,
                                           input logic [31:0] nt);
        in_word_t w;
        w.command        = cmd;
        w.timer_now      = timer;
        w.channel        = ch;
        w.period_seconds = period;
        w.new_time       = nt;
        return w;
    endfunction

    // Wait until every word is taken and every reading is back, then settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_words.size() > 0 || in_valid || due_readings.size() > 0);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_tps(input logic [31:0] value);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        model_tps = value;
        tps_cur   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly plausible timer progress and short periods, some noise
    task automatic queue_random(input int count);
        in_word_t w;
        int       pick;
        repeat (count)
        begin
            w = make_word(CMD_NOP, $urandom, CHAN_W'($urandom_range(0, 15)), $urandom,
                          $urandom);
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                w.command = CMD_POLL;
                case ($urandom_range(9))
                    0:       timer_clock = $urandom;
                    1, 2:    timer_clock = timer_clock + $urandom_range(0, 255);
                    default: timer_clock = timer_clock + tps_cur * $urandom_range(0, 3)
                                           + $urandom_range(0, 6) - 3;
                endcase
                w.timer_now = timer_clock;
            end
            else if (pick < 85)
            begin
                w.command = CMD_QUERY;
                case ($urandom_range(9))
                    0:       ;
                    1:       w.period_seconds = 32'hFFFF_FFFF;
                    default: w.period_seconds = $urandom_range(0, 4);
                endcase
            end
            else if (pick < 95)
            begin
                w.command = CMD_SET;
                if ($urandom_range(1) == 0)
                    w.new_time = 32'hFFFF_FFFF - $urandom_range(0, 5);
            end
            pending_words.push_back(w);
        end
    endtask

    initial
    begin
        for (int i = 0; i < N_CHAN; i++)
        begin
            chan_fire_time[i] = '0;
            chan_seen[i]      = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: first and repeat queries, second boundaries, wraps, unused code
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd0, 32'hFFFF_FFFF, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd0, 32'hFFFF_FFFF, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd0, 32'd0, '0));
        pending_words.push_back(make_word(CMD_POLL, TPS_RESET - 1, 4'd0, '0, '0));
        pending_words.push_back(make_word(CMD_POLL, TPS_RESET, 4'd0, '0, '0));
        pending_words.push_back(make_word(CMD_POLL, TPS_RESET * 3 + 7, 4'd0, '0, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd0, 32'd2, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd15, 32'd0, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd15, 32'd1, '0));
        pending_words.push_back(make_word(CMD_SET, '0, 4'd0, '0, 32'hFFFF_FFFF));
        pending_words.push_back(make_word(CMD_POLL, TPS_RESET * 5 + 7, 4'd0, '0, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd0, 32'hFFFF_FFFF, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd0, 32'hFFFF_FFFE, '0));
        pending_words.push_back(make_word(CMD_NOP, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF));
        pending_words.push_back(make_word(CMD_POLL, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF));
        pending_words.push_back(make_word(CMD_POLL, '0, '0, '0, '0));
        pending_words.push_back(make_word(CMD_SET, '0, 4'd7, '0, '0));
        pending_words.push_back(make_word(CMD_NOP, '0, '0, '0, '0));
        pending_words.push_back(make_word(CMD_QUERY, '0, 4'd15, 32'd0, '0));
        queue_random(PHASE_ITEMS - 19);

        // One tick per second: every poll catches up fully
        write_tps(32'd1);
        queue_random(PHASE_ITEMS);

        // Largest period: at most one second per poll
        write_tps(32'hFFFF_FFFF);
        queue_random(PHASE_ITEMS);

        // Zero ticks: polls leave the clock alone
        write_tps('0);
        queue_random(PHASE_ITEMS);

        // Small period with no idling on either side
        write_tps($urandom_range(2, 5000));
        idle_pct = 0;
        queue_random(PHASE_ITEMS);

        write_tps($urandom);
        idle_pct = IDLE_PCT;
        queue_random(PHASE_ITEMS);

        write_tps(TPS_RESET);
        queue_random(PHASE_ITEMS);

        drain();
        if (fault_count == 0 && due_readings.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
